// ===== hdl/fpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_pkg: shared types, constants and helpers for the frame point transform
// Holds the point word carried down the pipeline, the register map and the
// 32-bit saturation helper used by every arithmetic stage.
// ----------------------------------------------------------------------------
package fpt_pkg;

  // default fraction width of coordinates and frame factors
  localparam int unsigned FRAC_BITS_DEF = 16;
  // fraction width of the rotation coefficients (Q1.14)
  localparam int unsigned ROT_FRAC = 14;

  // register reset values
  localparam logic [1:0]  MODE_RESET = 2'd2;
  localparam logic [31:0] ROT_RESET  = 32'h4000_0000;

  // mode bit positions
  localparam int unsigned MODE_ORDER_BIT  = 0;
  localparam int unsigned MODE_BYPASS_BIT = 1;

  // configuration register map
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_ORIGIN_X  = 3'd1,
    REG_ORIGIN_Y  = 3'd2,
    REG_ROT       = 3'd3,
    REG_STRETCH_X = 3'd4,
    REG_STRETCH_Y = 3'd5,
    REG_SHEAR_X   = 3'd6,
    REG_SHEAR_Y   = 3'd7
  } fpt_reg_e;

  // point word travelling down the pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
    logic               last;
  } fpt_pt_t;

  // saturated value with its overflow mark
  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } fpt_sat_t;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  // clamp a wide signed value to 32 signed bits
  function automatic fpt_sat_t sat32(input logic signed [63:0] v);
    fpt_sat_t r;
    if (v > SAT_MAX) begin
      r.ovf = 1'b1;
      r.val = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r.ovf = 1'b1;
      r.val = SAT_MIN[31:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fpt_xlate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_xlate: origin add stage
// Adds the frame origin to the point and saturates, in one register stage.
// When disabled the word passes through unchanged with the same latency.
// ----------------------------------------------------------------------------
module fpt_xlate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [31:0] origin_x_i,
  input  wire logic signed [31:0] origin_y_i,
  input  wire logic               in_vld_i,
  input  wire fpt_pkg::fpt_pt_t   in_pt_i,
  output logic                    out_vld_o,
  output fpt_pkg::fpt_pt_t        out_pt_o
);

  logic signed [63:0] xe, ye, oxe, oye;
  fpt_pkg::fpt_sat_t  sat_x, sat_y;
  fpt_pkg::fpt_pt_t   pt_d, pt_q;
  logic               vld_q;

  // widened sums and clamp
  always_comb begin
    xe    = in_pt_i.x;
    ye    = in_pt_i.y;
    oxe   = origin_x_i;
    oye   = origin_y_i;
    sat_x = fpt_pkg::sat32(xe + oxe);
    sat_y = fpt_pkg::sat32(ye + oye);
    pt_d  = in_pt_i;
    if (en_i) begin
      pt_d.x   = sat_x.val;
      pt_d.y   = sat_y.val;
      pt_d.ovf = in_pt_i.ovf | sat_x.ovf | sat_y.ovf;
    end
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= in_vld_i;
    end
  end

  // payload word
  always_ff @(posedge clk_i) begin
    pt_q <= pt_d;
  end

  assign out_vld_o = vld_q;
  assign out_pt_o  = pt_q;

endmodule
`default_nettype wire

// ===== hdl/fpt_shear.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_shear: shear stage
// Stage one forms y*shear_x and x*shear_y; stage two shifts them down,
// adds the other coordinate and saturates.
// ----------------------------------------------------------------------------
module fpt_shear #(
  parameter int unsigned FRAC_BITS = fpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [31:0] shear_x_i,
  input  wire logic signed [31:0] shear_y_i,
  input  wire logic               in_vld_i,
  input  wire fpt_pkg::fpt_pt_t   in_pt_i,
  output logic                    out_vld_o,
  output fpt_pkg::fpt_pt_t        out_pt_o
);

  logic               vld_a_q, vld_b_q;
  fpt_pkg::fpt_pt_t   pt_a_q, pt_b_d, pt_b_q;
  logic signed [63:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [63:0] xe, ye, px_sh, py_sh;
  fpt_pkg::fpt_sat_t  sat_x, sat_y;

  // products
  always_comb begin
    prod_x_d = in_pt_i.y * shear_x_i;
    prod_y_d = in_pt_i.x * shear_y_i;
  end

  // shift, add and clamp
  always_comb begin
    xe     = pt_a_q.x;
    ye     = pt_a_q.y;
    px_sh  = prod_x_q >>> FRAC_BITS;
    py_sh  = prod_y_q >>> FRAC_BITS;
    sat_x  = fpt_pkg::sat32(xe + px_sh);
    sat_y  = fpt_pkg::sat32(ye + py_sh);
    pt_b_d = pt_a_q;
    if (en_i) begin
      pt_b_d.x   = sat_x.val;
      pt_b_d.y   = sat_y.val;
      pt_b_d.ovf = pt_a_q.ovf | sat_x.ovf | sat_y.ovf;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= in_vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pt_a_q   <= in_pt_i;
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    pt_b_q   <= pt_b_d;
  end

  assign out_vld_o = vld_b_q;
  assign out_pt_o  = pt_b_q;

endmodule
`default_nettype wire

// ===== hdl/fpt_stretch.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_stretch: stretch stage
// Stage one multiplies each coordinate by its scale factor; stage two
// shifts the products down and saturates.
// ----------------------------------------------------------------------------
module fpt_stretch #(
  parameter int unsigned FRAC_BITS = fpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [31:0] stretch_x_i,
  input  wire logic signed [31:0] stretch_y_i,
  input  wire logic               in_vld_i,
  input  wire fpt_pkg::fpt_pt_t   in_pt_i,
  output logic                    out_vld_o,
  output fpt_pkg::fpt_pt_t        out_pt_o
);

  logic               vld_a_q, vld_b_q;
  fpt_pkg::fpt_pt_t   pt_a_q, pt_b_d, pt_b_q;
  logic signed [63:0] prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [63:0] px_sh, py_sh;
  fpt_pkg::fpt_sat_t  sat_x, sat_y;

  // products
  always_comb begin
    prod_x_d = in_pt_i.x * stretch_x_i;
    prod_y_d = in_pt_i.y * stretch_y_i;
  end

  // shift and clamp
  always_comb begin
    px_sh  = prod_x_q >>> FRAC_BITS;
    py_sh  = prod_y_q >>> FRAC_BITS;
    sat_x  = fpt_pkg::sat32(px_sh);
    sat_y  = fpt_pkg::sat32(py_sh);
    pt_b_d = pt_a_q;
    if (en_i) begin
      pt_b_d.x   = sat_x.val;
      pt_b_d.y   = sat_y.val;
      pt_b_d.ovf = pt_a_q.ovf | sat_x.ovf | sat_y.ovf;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= in_vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pt_a_q   <= in_pt_i;
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    pt_b_q   <= pt_b_d;
  end

  assign out_vld_o = vld_b_q;
  assign out_pt_o  = pt_b_q;

endmodule
`default_nettype wire

// ===== hdl/fpt_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_rotate: rotation stage
// Stage one forms the four coordinate-by-coefficient products (32 x 16);
// stage two combines them, shifts by the Q1.14 fraction and saturates.
// ----------------------------------------------------------------------------
module fpt_rotate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic signed [15:0] cos_i,
  input  wire logic signed [15:0] sin_i,
  input  wire logic               in_vld_i,
  input  wire fpt_pkg::fpt_pt_t   in_pt_i,
  output logic                    out_vld_o,
  output fpt_pkg::fpt_pt_t        out_pt_o
);

  logic               vld_a_q, vld_b_q;
  fpt_pkg::fpt_pt_t   pt_a_q, pt_b_d, pt_b_q;
  logic signed [47:0] xc_d, xs_d, yc_d, ys_d;
  logic signed [47:0] xc_q, xs_q, yc_q, ys_q;
  logic signed [63:0] xc_w, xs_w, yc_w, ys_w, rx_sh, ry_sh;
  fpt_pkg::fpt_sat_t  sat_x, sat_y;

  // products
  always_comb begin
    xc_d = in_pt_i.x * cos_i;
    xs_d = in_pt_i.x * sin_i;
    yc_d = in_pt_i.y * cos_i;
    ys_d = in_pt_i.y * sin_i;
  end

  // combine, shift and clamp
  always_comb begin
    xc_w   = xc_q;
    xs_w   = xs_q;
    yc_w   = yc_q;
    ys_w   = ys_q;
    rx_sh  = (xc_w - ys_w) >>> fpt_pkg::ROT_FRAC;
    ry_sh  = (xs_w + yc_w) >>> fpt_pkg::ROT_FRAC;
    sat_x  = fpt_pkg::sat32(rx_sh);
    sat_y  = fpt_pkg::sat32(ry_sh);
    pt_b_d = pt_a_q;
    if (en_i) begin
      pt_b_d.x   = sat_x.val;
      pt_b_d.y   = sat_y.val;
      pt_b_d.ovf = pt_a_q.ovf | sat_x.ovf | sat_y.ovf;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= in_vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pt_a_q <= in_pt_i;
    xc_q   <= xc_d;
    xs_q   <= xs_d;
    yc_q   <= yc_d;
    ys_q   <= ys_d;
    pt_b_q <= pt_b_d;
  end

  assign out_vld_o = vld_b_q;
  assign out_pt_o  = pt_b_q;

endmodule
`default_nettype wire

// ===== hdl/frame_point_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_point_transform: maps a 2D fixed-point point into its parent frame
// Usage:
//   Points enter on start with point_x_i, point_y_i and last_in_i. busy is
//   never raised, so a point is taken on every cycle that start is high.
//   Each result appears on result_x_o, result_y_o, overflow_o and
//   last_out_o for one cycle, marked by res_strobe_o, once its point has
//   passed every stage register of the chain below. Throughput is one
//   point per cycle; the depth is set by the seven stage chain: origin add
//   (1), shear (2), stretch (2), rotate (2), stretch (2), shear (2), origin
//   add (1), with a register after every multiplier bank. Mode bit0 picks
//   which shear/stretch/origin slots are active, so both orders share the
//   one rotate unit; mode bit1 passes points through.
//   Results are always taken on the strobe cycle: there is no back-pressure.
//   Frame registers are written on the cfg word channel (cfg_ready_o always
//   high) while no points are in flight; only the user ensures this. Reset
//   clears all in-flight points and loads the identity frame with bypass set.
// ----------------------------------------------------------------------------
module frame_point_transform #(
  parameter int unsigned FRAC_BITS = fpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // point channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic               last_in_i,
  // result channel
  output logic                    res_strobe_o,
  output logic signed [31:0]      result_x_o,
  output logic signed [31:0]      result_y_o,
  output logic                    overflow_o,
  output logic                    last_out_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam logic [31:0] STRETCH_ONE = 32'(64'd1 << FRAC_BITS);

  // frame registers
  logic [1:0]         mode_q;
  logic signed [31:0] origin_x_q, origin_y_q;
  logic [31:0]        rot_q;
  logic signed [31:0] stretch_x_q, stretch_y_q, shear_x_q, shear_y_q;

  logic               bypass, order1, en_fwd, en_rev, en_rot;
  logic signed [15:0] rot_cos, rot_sin;
  logic               in_vld;
  fpt_pkg::fpt_pt_t   in_pt;

  // stage chain links
  logic               v1, v2, v3, v4, v5, v6, v7;
  fpt_pkg::fpt_pt_t   p1, p2, p3, p4, p5, p6, p7;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= fpt_pkg::MODE_RESET;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      rot_q       <= fpt_pkg::ROT_RESET;
      stretch_x_q <= STRETCH_ONE;
      stretch_y_q <= STRETCH_ONE;
      shear_x_q   <= '0;
      shear_y_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (fpt_pkg::fpt_reg_e'(cfg_index_i))
        fpt_pkg::REG_MODE:      mode_q      <= cfg_data_i[1:0];
        fpt_pkg::REG_ORIGIN_X:  origin_x_q  <= cfg_data_i;
        fpt_pkg::REG_ORIGIN_Y:  origin_y_q  <= cfg_data_i;
        fpt_pkg::REG_ROT:       rot_q       <= cfg_data_i;
        fpt_pkg::REG_STRETCH_X: stretch_x_q <= cfg_data_i;
        fpt_pkg::REG_STRETCH_Y: stretch_y_q <= cfg_data_i;
        fpt_pkg::REG_SHEAR_X:   shear_x_q   <= cfg_data_i;
        fpt_pkg::REG_SHEAR_Y:   shear_y_q   <= cfg_data_i;
        default:                mode_q      <= mode_q;
      endcase
    end
  end

  // slot enables from the mode
  assign bypass  = mode_q[fpt_pkg::MODE_BYPASS_BIT];
  assign order1  = mode_q[fpt_pkg::MODE_ORDER_BIT];
  assign en_fwd  = !bypass && !order1;
  assign en_rev  = !bypass && order1;
  assign en_rot  = !bypass;
  assign rot_cos = rot_q[31:16];
  assign rot_sin = rot_q[15:0];

  // incoming word
  assign in_vld = start && !busy;
  always_comb begin
    in_pt.x    = point_x_i;
    in_pt.y    = point_y_i;
    in_pt.ovf  = 1'b0;
    in_pt.last = last_in_i;
  end

  // origin add, reverse order
  fpt_xlate u_xlate_pre (
    .clk_i, .rst_ni, .en_i(en_rev),
    .origin_x_i(origin_x_q), .origin_y_i(origin_y_q),
    .in_vld_i(in_vld), .in_pt_i(in_pt), .out_vld_o(v1), .out_pt_o(p1)
  );

  // shear, forward order
  fpt_shear #(.FRAC_BITS(FRAC_BITS)) u_shear_fwd (
    .clk_i, .rst_ni, .en_i(en_fwd),
    .shear_x_i(shear_x_q), .shear_y_i(shear_y_q),
    .in_vld_i(v1), .in_pt_i(p1), .out_vld_o(v2), .out_pt_o(p2)
  );

  // stretch, forward order
  fpt_stretch #(.FRAC_BITS(FRAC_BITS)) u_stretch_fwd (
    .clk_i, .rst_ni, .en_i(en_fwd),
    .stretch_x_i(stretch_x_q), .stretch_y_i(stretch_y_q),
    .in_vld_i(v2), .in_pt_i(p2), .out_vld_o(v3), .out_pt_o(p3)
  );

  // rotation, both orders
  fpt_rotate u_rotate (
    .clk_i, .rst_ni, .en_i(en_rot),
    .cos_i(rot_cos), .sin_i(rot_sin),
    .in_vld_i(v3), .in_pt_i(p3), .out_vld_o(v4), .out_pt_o(p4)
  );

  // stretch, reverse order
  fpt_stretch #(.FRAC_BITS(FRAC_BITS)) u_stretch_rev (
    .clk_i, .rst_ni, .en_i(en_rev),
    .stretch_x_i(stretch_x_q), .stretch_y_i(stretch_y_q),
    .in_vld_i(v4), .in_pt_i(p4), .out_vld_o(v5), .out_pt_o(p5)
  );

  // shear, reverse order
  fpt_shear #(.FRAC_BITS(FRAC_BITS)) u_shear_rev (
    .clk_i, .rst_ni, .en_i(en_rev),
    .shear_x_i(shear_x_q), .shear_y_i(shear_y_q),
    .in_vld_i(v5), .in_pt_i(p5), .out_vld_o(v6), .out_pt_o(p6)
  );

  // origin add, forward order
  fpt_xlate u_xlate_post (
    .clk_i, .rst_ni, .en_i(en_fwd),
    .origin_x_i(origin_x_q), .origin_y_i(origin_y_q),
    .in_vld_i(v6), .in_pt_i(p6), .out_vld_o(v7), .out_pt_o(p7)
  );

  // result ports straight from the last stage register
  assign res_strobe_o = v7;
  assign result_x_o   = p7.x;
  assign result_y_o   = p7.y;
  assign overflow_o   = p7.ovf;
  assign last_out_o   = p7.last;

endmodule
`default_nettype wire

// ===== hdl/fpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpt_checker: port-level checks for the frame point transform
// Checks the fixed pipeline latency in both directions and that the batch
// marker travels with its point.
// ----------------------------------------------------------------------------
module fpt_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic last_in_i,
  input wire logic res_strobe_o,
  input wire logic last_out_o
);

  localparam int unsigned LAT = 12;

  // every accepted point gives a result after the fixed latency
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT res_strobe_o)
    else $error("accepted point produced no result");

  // no result without a point accepted at the matching edge
  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start && !busy, LAT))
    else $error("result word with no matching point");

  // batch marker follows its point
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (last_out_o == $past(last_in_i, LAT)))
    else $error("last marker does not match its point");

endmodule

bind frame_point_transform fpt_checker u_fpt_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .last_in_i(last_in_i),
  .res_strobe_o(res_strobe_o),
  .last_out_o(last_out_o)
);
`default_nettype wire

// ===== test/frame_point_transform_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_point_transform_tb: self-checking bench for the frame point transform
// Loads frame settings over the cfg word channel while the pipe is empty,
// streams points with random gaps and predicts each transformed point with
// its own fixed-point model of both orders, bypass and saturation. Every
// strobed result word is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module frame_point_transform_tb;

  localparam int FRAC          = fpt_pkg::FRAC_BITS_DEF;
  localparam int PIPE_LATENCY  = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 16;

  // mode codes
  localparam logic [1:0] MODE_SHEAR_FIRST  = 2'd0;
  localparam logic [1:0] MODE_ORIGIN_FIRST = 2'd1;
  localparam logic [1:0] MODE_BYPASS       = 2'd2;
  localparam logic [1:0] MODE_BYPASS_ALT   = 2'd3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // frame settings as held in the block's registers
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [31:0]        rot;
    logic signed [31:0] stretch_x;
    logic signed [31:0] stretch_y;
    logic signed [31:0] shear_x;
    logic signed [31:0] shear_y;
  } frame_cfg_t;

  // one transformed point
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
    logic               last;
  } mapped_point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic               last_in_i = 1'b0;
  logic               res_strobe_o;
  logic signed [31:0] result_x_o;
  logic signed [31:0] result_y_o;
  logic               overflow_o;
  logic               last_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  frame_cfg_t    cur_frame;
  mapped_point_t expected_points[$];
  int            error_count = 0;
  int            stall_cycles = 0;
  bit            idle_on = 1'b1;

  frame_point_transform u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_in_i    (last_in_i),
    .res_strobe_o (res_strobe_o),
    .result_x_o   (result_x_o),
    .result_y_o   (result_y_o),
    .overflow_o   (overflow_o),
    .last_out_o   (last_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // point predictor
  // ---------------------------------------------------------------------------

  // clamp to 32 signed bits, marking any clipping
  function automatic longint clamp_word(input longint v, inout bit ovf);
    if (v > longint'(Q_MAX)) begin
      ovf = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      ovf = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  function automatic void apply_shear(input frame_cfg_t f, inout longint px,
                                      inout longint py, inout bit ovf);
    longint ox, oy, gx, gy;
    ox = px;
    oy = py;
    gx = $signed(f.shear_x);
    gy = $signed(f.shear_y);
    px = clamp_word(ox + ((oy * gx) >>> FRAC), ovf);
    py = clamp_word(oy + ((ox * gy) >>> FRAC), ovf);
  endfunction

  function automatic void apply_stretch(input frame_cfg_t f, inout longint px,
                                        inout longint py, inout bit ovf);
    longint kx, ky;
    kx = $signed(f.stretch_x);
    ky = $signed(f.stretch_y);
    px = clamp_word((px * kx) >>> FRAC, ovf);
    py = clamp_word((py * ky) >>> FRAC, ovf);
  endfunction

  function automatic void apply_rotate(input frame_cfg_t f, inout longint px,
                                       inout longint py, inout bit ovf);
    longint ox, oy, c, s;
    ox = px;
    oy = py;
    c  = $signed(f.rot[31:16]);
    s  = $signed(f.rot[15:0]);
    px = clamp_word(((ox * c) - (oy * s)) >>> fpt_pkg::ROT_FRAC, ovf);
    py = clamp_word(((ox * s) + (oy * c)) >>> fpt_pkg::ROT_FRAC, ovf);
  endfunction

  function automatic void apply_origin(input frame_cfg_t f, inout longint px,
                                       inout longint py, inout bit ovf);
    longint dx, dy;
    dx = $signed(f.origin_x);
    dy = $signed(f.origin_y);
    px = clamp_word(px + dx, ovf);
    py = clamp_word(py + dy, ovf);
  endfunction

  // map one point from the local frame into the parent frame
  function automatic mapped_point_t transform_point(input frame_cfg_t f,
                                                    input logic signed [31:0] x,
                                                    input logic signed [31:0] y,
                                                    input logic last);
    mapped_point_t r;
    longint        px, py;
    bit            ovf;
    px  = x;
    py  = y;
    ovf = 1'b0;
    if (!f.mode[fpt_pkg::MODE_BYPASS_BIT]) begin
      if (!f.mode[fpt_pkg::MODE_ORDER_BIT]) begin
        apply_shear(f, px, py, ovf);
        apply_stretch(f, px, py, ovf);
        apply_rotate(f, px, py, ovf);
        apply_origin(f, px, py, ovf);
      end else begin
        apply_origin(f, px, py, ovf);
        apply_rotate(f, px, py, ovf);
        apply_stretch(f, px, py, ovf);
        apply_shear(f, px, py, ovf);
      end
    end
    r.x    = px[31:0];
    r.y    = py[31:0];
    r.ovf  = ovf;
    r.last = last;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic frame_cfg_t reset_frame();
    frame_cfg_t f;
    f.mode      = fpt_pkg::MODE_RESET;
    f.origin_x  = '0;
    f.origin_y  = '0;
    f.rot       = fpt_pkg::ROT_RESET;
    f.stretch_x = Q_ONE;
    f.stretch_y = Q_ONE;
    f.shear_x   = '0;
    f.shear_y   = '0;
    return f;
  endfunction

  // signed random value spanning the given number of bits
  function automatic logic signed [31:0] rand_field(input int bits);
    logic signed [31:0] r;
    r = $urandom;
    return r >>> (32 - bits);
  endfunction

  function automatic logic signed [31:0] pick_corner();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      5:       return Q_ONE;
      6:       return -Q_ONE;
      default: return 32'sh0000_FFFF;
    endcase
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 9))
      7, 8:    return $urandom;
      9:       return pick_corner();
      default: return rand_field($urandom_range(12, 26));
    endcase
  endfunction

  // mostly usable frames, some raw and some built from corner values
  function automatic frame_cfg_t random_frame();
    frame_cfg_t         f;
    int                 flavour;
    logic signed [31:0] c_word, s_word;
    flavour = $urandom_range(0, 9);
    case (flavour)
      0: begin
        f.origin_x  = $urandom;
        f.origin_y  = $urandom;
        f.rot       = $urandom;
        f.stretch_x = $urandom;
        f.stretch_y = $urandom;
        f.shear_x   = $urandom;
        f.shear_y   = $urandom;
      end
      1: begin
        f.origin_x  = pick_corner();
        f.origin_y  = pick_corner();
        c_word      = pick_corner();
        s_word      = pick_corner();
        f.rot       = {c_word[15:0], s_word[31:16]};
        f.stretch_x = pick_corner();
        f.stretch_y = pick_corner();
        f.shear_x   = pick_corner();
        f.shear_y   = pick_corner();
      end
      default: begin
        f.origin_x  = rand_field(24);
        f.origin_y  = rand_field(24);
        c_word      = rand_field(16);
        s_word      = rand_field(16);
        f.rot       = {c_word[15:0], s_word[15:0]};
        f.stretch_x = rand_field(19);
        f.stretch_y = rand_field(19);
        f.shear_x   = rand_field(17);
        f.shear_y   = rand_field(17);
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      f.mode = $urandom_range(0, 1) ? MODE_BYPASS : MODE_BYPASS_ALT;
    end else begin
      f.mode = $urandom_range(0, 1) ? MODE_ORIGIN_FIRST : MODE_SHEAR_FIRST;
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------------

  // offer one point, optionally after an idle burst, and log its prediction
  task automatic send_point(input logic signed [31:0] x,
                            input logic signed [31:0] y,
                            input logic last);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    start     = 1'b1;
    point_x_i = x;
    point_y_i = y;
    last_in_i = last;
    do @(posedge clk_i); while (busy);
    expected_points.push_back(transform_point(cur_frame, x, y, last));
  endtask

  // stop offering points and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input fpt_pkg::fpt_reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // write every frame register with the pipe empty
  task automatic load_frame(input frame_cfg_t f);
    logic [31:0]       word;
    fpt_pkg::fpt_reg_e idx;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      idx = fpt_pkg::fpt_reg_e'(i);
      case (idx)
        fpt_pkg::REG_MODE:      word = {30'd0, f.mode};
        fpt_pkg::REG_ORIGIN_X:  word = f.origin_x;
        fpt_pkg::REG_ORIGIN_Y:  word = f.origin_y;
        fpt_pkg::REG_ROT:       word = f.rot;
        fpt_pkg::REG_STRETCH_X: word = f.stretch_x;
        fpt_pkg::REG_STRETCH_Y: word = f.stretch_y;
        fpt_pkg::REG_SHEAR_X:   word = f.shear_x;
        default:                word = f.shear_y;
      endcase
      write_reg(idx, word);
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cur_frame   = f;
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    mapped_point_t want;
    if (rst_ni && res_strobe_o) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result word x %h y %h", $time, result_x_o,
                 result_y_o);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (result_x_o !== want.x) begin
          $display("%0t: result_x mismatch, expected %h, got %h", $time, want.x,
                   result_x_o);
          error_count++;
        end
        if (result_y_o !== want.y) begin
          $display("%0t: result_y mismatch, expected %h, got %h", $time, want.y,
                   result_y_o);
          error_count++;
        end
        if (overflow_o !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %b, got %b", $time,
                   want.ovf, overflow_o);
          error_count++;
        end
        if (last_out_o !== want.last) begin
          $display("%0t: last_out mismatch, expected %b, got %b", $time,
                   want.last, last_out_o);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // bypass is set out of reset: points come back untouched
  task automatic test_bypass_after_reset();
    send_point(Q_MAX, Q_MIN, 1'b1);
    send_point(Q_MIN, Q_MAX, 1'b0);
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(-32'sd1, 32'sd1, 1'b0);
  endtask

  // identity frame through both orders
  task automatic test_identity_orders();
    frame_cfg_t f;
    f = reset_frame();
    f.mode = MODE_SHEAR_FIRST;
    load_frame(f);
    send_point(Q_MAX, Q_MIN, 1'b0);
    send_point(32'sd123456, -32'sd98765, 1'b1);
    f.mode = MODE_ORIGIN_FIRST;
    load_frame(f);
    send_point(Q_MAX, Q_MIN, 1'b0);
    send_point(32'sd123456, -32'sd98765, 1'b1);
  endtask

  // extreme factors and origins driving every stage into clipping
  task automatic test_saturation_corners();
    frame_cfg_t f;
    f = reset_frame();
    f.mode      = MODE_SHEAR_FIRST;
    f.stretch_x = Q_MAX;
    f.stretch_y = Q_MIN;
    load_frame(f);
    send_point(Q_MAX, Q_MAX, 1'b1);
    send_point(Q_MIN, 32'sd1, 1'b0);
    send_point(Q_ONE, -Q_ONE, 1'b1);
    f = reset_frame();
    f.mode     = MODE_ORIGIN_FIRST;
    f.origin_x = Q_MAX;
    f.origin_y = Q_MIN;
    f.shear_x  = Q_MIN;
    f.shear_y  = Q_MAX;
    f.rot      = 32'h8000_7FFF;
    load_frame(f);
    send_point(Q_MAX, Q_MIN, 1'b0);
    send_point(-32'sd1, -32'sd1, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
  endtask

  // odd factors on small negative points, where the floor shift shows
  task automatic test_floor_rounding();
    frame_cfg_t f;
    f = reset_frame();
    f.mode      = MODE_SHEAR_FIRST;
    f.rot       = 32'h2D41_D2BF;
    f.origin_x  = -32'sd3;
    f.origin_y  = 32'sd5;
    f.stretch_x = 32'sh0000_8001;
    f.stretch_y = -32'sh0001_8000;
    f.shear_x   = 32'sd1;
    f.shear_y   = -32'sd1;
    load_frame(f);
    send_point(-32'sd1, -32'sd3, 1'b0);
    send_point(-32'sd65537, 32'sd3, 1'b1);
    f.mode = MODE_ORIGIN_FIRST;
    load_frame(f);
    send_point(-32'sd1, -32'sd3, 1'b0);
    send_point(-32'sd65537, 32'sd3, 1'b1);
    // bypass with the order bit also set ignores the whole frame
    f.mode = MODE_BYPASS_ALT;
    load_frame(f);
    send_point(Q_MAX, -32'sd1, 1'b1);
    send_point(Q_MIN, 32'sd7, 1'b0);
  endtask

  // random frames, each followed by a burst of random points
  task automatic test_random_frames();
    int count;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase >= RANDOM_PHASES - 2) idle_on = 1'b0;
      load_frame(random_frame());
      count = $urandom_range(42, 52);
      for (int k = 0; k < count; k++) begin
        send_point(random_coord(), random_coord(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    cur_frame = reset_frame();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_bypass_after_reset();
    test_identity_orders();
    test_saturation_corners();
    test_floor_rounding();
    test_random_frames();

    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
